// ===== hw/rtl/scpt_pkg.sv =====
`default_nettype none

package scpt_pkg;

  localparam logic [1:0] ACT_READ    = 2'd0;
  localparam logic [1:0] ACT_WRITE   = 2'd1;
  localparam logic [1:0] ACT_ADVANCE = 2'd2;

  localparam logic [2:0] REG_DURATION_PHONEME  = 3'd0;
  localparam logic [2:0] REG_INFLECTION        = 3'd1;
  localparam logic [2:0] REG_RATE_INFLECTION   = 3'd2;
  localparam logic [2:0] REG_CONTROL_AMPLITUDE = 3'd3;
  localparam logic [2:0] REG_FILTER_FREQUENCY  = 3'd4;

  localparam int          COUNT_W     = 18;
  localparam int          MS_PER_S    = 1000;
  localparam int          CTL_BIT     = 7;
  localparam logic [7:0]  STATUS_REQ  = 8'h80;
  localparam logic [7:0]  CONTROL_RST = 8'h80;

  typedef logic [COUNT_W-1:0] count_t;

  // Base phoneme length in milliseconds for each rate code, (16 - rate) * 4096 / 1023.
  localparam logic [6:0] BASE_MS [16] = '{
    7'd64, 7'd60, 7'd56, 7'd52, 7'd48, 7'd44, 7'd40, 7'd36,
    7'd32, 7'd28, 7'd24, 7'd20, 7'd16, 7'd12, 7'd8,  7'd4
  };

endpackage

`default_nettype wire

// ===== hw/rtl/speech_chip_phoneme_timer.sv =====
`default_nettype none

// Register and phoneme timing block of a speech synthesizer. Each command transfer is a
// status read, a register write or an advance of elapsed clock cycles, and each one yields
// exactly one response transfer via the response register. A command is taken in every
// cycle as long as the response register is empty or its response is being taken in that
// cycle, so the sustained rate is one command per cycle; the whole update is one table
// lookup and an 18-bit compare and subtract between the state and response registers.
// Phoneme durations come from a 64-entry table built at elaboration from CLOCK_HZ.
module speech_chip_phoneme_timer #(
  parameter int CLOCK_HZ = 1022727
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cmd_valid,
  output logic            cmd_stall,
  input  wire logic [1:0] action,
  input  wire logic [2:0] reg_index,
  input  wire logic [7:0] write_data,
  input  wire logic [15:0] tick_cycles,
  output logic            rsp_valid,
  input  wire logic       rsp_stall,
  output logic [7:0]      read_data,
  output logic            request_cleared,
  output logic            request_raised
);
  import scpt_pkg::*;

  typedef count_t cyc_table_t [64];

  function automatic cyc_table_t build_table();
    cyc_table_t tbl;
    longint     ms;
    longint     cyc;
    for (int r = 0; r < 16; r++) begin
      for (int m = 0; m < 4; m++) begin
        ms  = longint'(BASE_MS[r]) * longint'(4 - m);
        cyc = (ms * longint'(CLOCK_HZ)) / MS_PER_S;
        if (cyc > longint'({COUNT_W{1'b1}})) begin
          cyc = longint'({COUNT_W{1'b1}});
        end
        tbl[r*4+m] = cyc[COUNT_W-1:0];
      end
    end
    return tbl;
  endfunction

  localparam cyc_table_t CYC_TABLE = build_table();

  logic [7:0] duration_phoneme, duration_phoneme_next;
  logic [7:0] inflection, inflection_next;
  logic [7:0] rate_inflection, rate_inflection_next;
  logic [7:0] control_amplitude, control_amplitude_next;
  logic [7:0] filter_frequency, filter_frequency_next;
  count_t     remaining_cycles, remaining_cycles_next;
  logic       request_flag, request_flag_next;

  logic [7:0] rd_next;
  logic       cleared_next;
  logic       raised_next;
  logic       accept;
  logic       powered_down;
  count_t     ticks_ext;

  assign cmd_stall    = rsp_valid && rsp_stall;
  assign accept       = cmd_valid && !cmd_stall;
  assign powered_down = control_amplitude[CTL_BIT];
  assign ticks_ext    = COUNT_W'(tick_cycles);

  always_comb begin
    duration_phoneme_next  = duration_phoneme;
    inflection_next        = inflection;
    rate_inflection_next   = rate_inflection;
    control_amplitude_next = control_amplitude;
    filter_frequency_next  = filter_frequency;
    remaining_cycles_next  = remaining_cycles;
    request_flag_next      = request_flag;
    rd_next                = 8'h00;
    cleared_next           = 1'b0;
    raised_next            = 1'b0;
    case (action)
      ACT_READ: begin
        rd_next = request_flag ? STATUS_REQ : 8'h00;
      end
      ACT_WRITE: begin
        if (reg_index inside {REG_DURATION_PHONEME, REG_INFLECTION,
                              REG_RATE_INFLECTION}) begin
          cleared_next      = request_flag;
          request_flag_next = 1'b0;
        end
        case (reg_index)
          REG_DURATION_PHONEME: begin
            duration_phoneme_next = write_data;
            if (!powered_down) begin
              remaining_cycles_next = CYC_TABLE[{rate_inflection[7:4], write_data[7:6]}];
            end
          end
          REG_INFLECTION: begin
            inflection_next = write_data;
          end
          REG_RATE_INFLECTION: begin
            rate_inflection_next = write_data;
          end
          REG_CONTROL_AMPLITUDE: begin
            control_amplitude_next = write_data;
            if (powered_down && !write_data[CTL_BIT]) begin
              remaining_cycles_next =
                CYC_TABLE[{rate_inflection[7:4], duration_phoneme[7:6]}];
            end
            if (!powered_down && write_data[CTL_BIT]) begin
              cleared_next          = request_flag;
              request_flag_next     = 1'b0;
              remaining_cycles_next = '0;
            end
          end
          REG_FILTER_FREQUENCY: begin
            filter_frequency_next = write_data;
          end
          default: begin
          end
        endcase
      end
      ACT_ADVANCE: begin
        if (tick_cycles != 16'd0 && remaining_cycles != '0 && !powered_down) begin
          if (remaining_cycles > ticks_ext) begin
            remaining_cycles_next = remaining_cycles - ticks_ext;
          end else begin
            remaining_cycles_next = '0;
            if (duration_phoneme[7:6] != 2'd0 && !request_flag) begin
              request_flag_next = 1'b1;
              raised_next       = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duration_phoneme  <= 8'h00;
      inflection        <= 8'h00;
      rate_inflection   <= 8'h00;
      control_amplitude <= CONTROL_RST;
      filter_frequency  <= 8'h00;
      remaining_cycles  <= '0;
      request_flag      <= 1'b0;
      rsp_valid         <= 1'b0;
    end else begin
      if (accept) begin
        duration_phoneme  <= duration_phoneme_next;
        inflection        <= inflection_next;
        rate_inflection   <= rate_inflection_next;
        control_amplitude <= control_amplitude_next;
        filter_frequency  <= filter_frequency_next;
        remaining_cycles  <= remaining_cycles_next;
        request_flag      <= request_flag_next;
        rsp_valid         <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data       <= rd_next;
      request_cleared <= cleared_next;
      request_raised  <= raised_next;
    end
  end

endmodule

`default_nettype wire

// ===== verif/phoneme_check_pkg.sv =====
package phoneme_check_pkg;
  import scpt_pkg::*;

  typedef struct packed {
    logic [7:0] read_data;
    logic       request_cleared;
    logic       request_raised;
  } status_t;

  class phoneme_timing_model;
    longint unsigned clock_hz;
    logic [7:0]      duration_reg;
    logic [7:0]      inflection_reg;
    logic [7:0]      rate_reg;
    logic [7:0]      control_reg;
    logic [7:0]      filter_reg;
    count_t          countdown;
    logic            request;
    status_t         status_q[$];
    int              errors;

    function new(longint unsigned hz);
      clock_hz       = hz;
      duration_reg   = '0;
      inflection_reg = '0;
      rate_reg       = '0;
      control_reg    = CONTROL_RST;
      filter_reg     = '0;
      countdown      = '0;
      request        = 1'b0;
      errors         = 0;
    endfunction

    function count_t phoneme_length();
      longint unsigned rate;
      longint unsigned mode;
      longint unsigned ms;
      longint unsigned cyc;
      longint unsigned cap;
      rate = rate_reg[7:4];
      mode = duration_reg[7:6];
      ms   = ((16 - rate) * 4096 / 1023) * (4 - mode);
      cyc  = ms * clock_hz / MS_PER_S;
      cap  = (longint'(1) << COUNT_W) - 1;
      if (cyc > cap) begin
        cyc = cap;
      end
      return count_t'(cyc);
    endfunction

    function void note_command(logic [1:0] act, logic [2:0] idx, logic [7:0] data,
                               logic [15:0] ticks);
      status_t want;
      logic    was_down;
      logic    now_down;
      want = '0;
      case (act)
        ACT_READ: begin
          want.read_data = request ? STATUS_REQ : 8'h00;
        end
        ACT_WRITE: begin
          if (idx <= REG_RATE_INFLECTION) begin
            want.request_cleared = request;
            request = 1'b0;
          end
          case (idx)
            REG_DURATION_PHONEME: begin
              duration_reg = data;
              if (!control_reg[CTL_BIT]) begin
                countdown = phoneme_length();
              end
            end
            REG_INFLECTION: inflection_reg = data;
            REG_RATE_INFLECTION: rate_reg = data;
            REG_CONTROL_AMPLITUDE: begin
              was_down    = control_reg[CTL_BIT];
              now_down    = data[CTL_BIT];
              control_reg = data;
              if (was_down && !now_down) begin
                countdown = phoneme_length();
              end
              if (!was_down && now_down) begin
                want.request_cleared = want.request_cleared | request;
                request   = 1'b0;
                countdown = '0;
              end
            end
            REG_FILTER_FREQUENCY: filter_reg = data;
            default: ;
          endcase
        end
        ACT_ADVANCE: begin
          if (ticks != 0 && countdown != 0 && !control_reg[CTL_BIT]) begin
            if (countdown > ticks) begin
              countdown = countdown - ticks;
            end else begin
              countdown = '0;
              if (duration_reg[7:6] != 2'b00 && !request) begin
                request             = 1'b1;
                want.request_raised = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
      status_q.push_back(want);
    endfunction

    function void check_status(logic [7:0] rd, logic cleared, logic raised);
      status_t want;
      if (status_q.size() == 0) begin
        $error("status transfer with no command outstanding");
        errors++;
        return;
      end
      want = status_q.pop_front();
      if (rd !== want.read_data) begin
        $error("read_data: expected %0h, got %0h", want.read_data, rd);
        errors++;
      end
      if (cleared !== want.request_cleared) begin
        $error("request_cleared: expected %0b, got %0b", want.request_cleared, cleared);
        errors++;
      end
      if (raised !== want.request_raised) begin
        $error("request_raised: expected %0b, got %0b", want.request_raised, raised);
        errors++;
      end
    endfunction

    function int pending();
      return status_q.size();
    endfunction
  endclass

endpackage

// ===== verif/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import scpt_pkg::*;
  import phoneme_check_pkg::*;

  localparam int         CLOCK_HZ     = 1022727;
  localparam int         RANDOM_ITEMS = 1025;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam logic [1:0] ACT_UNUSED   = 2'd3;

  logic        clk;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  logic [1:0]  action = ACT_READ;
  logic [2:0]  reg_index = '0;
  logic [7:0]  write_data = '0;
  logic [15:0] tick_cycles = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [7:0]  read_data;
  logic        request_cleared;
  logic        request_raised;

  logic quiet_tail = 1'b0;
  logic send_calm = 1'b0;
  int   cycle_count = 0;

  phoneme_timing_model chip_model = new(CLOCK_HZ);

  speech_chip_phoneme_timer #(
    .CLOCK_HZ(CLOCK_HZ)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .action(action),
    .reg_index(reg_index),
    .write_data(write_data),
    .tick_cycles(tick_cycles),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .read_data(read_data),
    .request_cleared(request_cleared),
    .request_raised(request_raised)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (cmd_valid && !cmd_stall) begin
        chip_model.note_command(action, reg_index, write_data, tick_cycles);
      end
      if (rsp_valid && !rsp_stall) begin
        chip_model.check_status(read_data, request_cleared, request_raised);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin : status_stall
    int run;
    @(posedge clk);
    forever begin
      run = $urandom_range(1, 18);
      if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
        run = run * $urandom_range(1, 4);
      end
      repeat (run) @(posedge clk);
    end
  end

  task automatic send_cmd(input logic [1:0] act, input logic [2:0] idx,
                          input logic [7:0] data, input logic [15:0] ticks);
    int gap;
    if ($urandom_range(0, 49) == 0) begin
      send_calm = !send_calm;
    end
    if (!quiet_tail && !send_calm && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 18);
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid   <= 1'b1;
    action      <= act;
    reg_index   <= idx;
    write_data  <= data;
    tick_cycles <= ticks;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
  endtask

  task automatic random_command();
    int          pick;
    logic [1:0]  act;
    logic [2:0]  idx;
    logic [7:0]  data;
    logic [15:0] ticks;
    pick  = $urandom_range(0, 99);
    idx   = 3'($urandom);
    data  = 8'($urandom);
    ticks = 16'($urandom);
    if (pick < 3) begin
      act = ACT_UNUSED;
    end else if (pick < 25) begin
      act = ACT_READ;
    end else if (pick < 58) begin
      act  = ACT_WRITE;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        idx = REG_DURATION_PHONEME;
      end else if (pick < 45) begin
        idx = REG_RATE_INFLECTION;
      end else if (pick < 60) begin
        idx = REG_CONTROL_AMPLITUDE;
        if ($urandom_range(0, 3) != 0) begin
          data[CTL_BIT] = 1'b0;
        end
      end else if (pick < 90) begin
        idx = 3'($urandom_range(REG_INFLECTION, REG_FILTER_FREQUENCY));
      end else begin
        idx = 3'($urandom_range(5, 7));
      end
    end else begin
      act  = ACT_ADVANCE;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        ticks = '0;
      end else if (pick < 25) begin
        ticks = 16'($urandom_range(1, 4095));
      end else if (pick < 60) begin
        ticks = 16'($urandom);
      end else begin
        ticks = 16'hFFFF;
      end
    end
    send_cmd(act, idx, data, ticks);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Idle chip, ignored registers and the unused action.
    send_cmd(ACT_READ, 3'd0, 8'h00, 16'h0000);
    send_cmd(ACT_WRITE, 3'd7, 8'hFF, 16'hFFFF);
    send_cmd(ACT_WRITE, 3'd5, 8'h00, 16'h0000);
    send_cmd(ACT_UNUSED, 3'd7, 8'hFF, 16'hFFFF);
    send_cmd(ACT_ADVANCE, 3'd0, 8'h00, 16'hFFFF);
    // Longest phoneme with mode zero expires without a request.
    send_cmd(ACT_WRITE, REG_DURATION_PHONEME, 8'h00, 16'h0000);
    send_cmd(ACT_WRITE, REG_CONTROL_AMPLITUDE, 8'h00, 16'h0000);
    repeat (4) send_cmd(ACT_ADVANCE, 3'd0, 8'h00, 16'hFFFF);
    send_cmd(ACT_ADVANCE, 3'd0, 8'h00, 16'h0000);
    send_cmd(ACT_READ, 3'd0, 8'h00, 16'h0000);
    // Shortest phoneme, expiring exactly on the last tick.
    send_cmd(ACT_WRITE, REG_RATE_INFLECTION, 8'hF0, 16'h0000);
    send_cmd(ACT_WRITE, REG_DURATION_PHONEME, 8'hC5, 16'h0000);
    send_cmd(ACT_ADVANCE, 3'd0, 8'h00, 16'd4089);
    send_cmd(ACT_ADVANCE, 3'd0, 8'h00, 16'd1);
    send_cmd(ACT_READ, 3'd0, 8'h00, 16'h0000);
    send_cmd(ACT_WRITE, REG_FILTER_FREQUENCY, 8'hFF, 16'h0000);
    send_cmd(ACT_WRITE, REG_INFLECTION, 8'h12, 16'h0000);
    // Power-down while a request is pending, then a restart on power-up.
    send_cmd(ACT_WRITE, REG_DURATION_PHONEME, 8'h7F, 16'h0000);
    send_cmd(ACT_ADVANCE, 3'd0, 8'h00, 16'hFFFF);
    send_cmd(ACT_WRITE, REG_CONTROL_AMPLITUDE, 8'h80, 16'h0000);
    send_cmd(ACT_WRITE, REG_CONTROL_AMPLITUDE, 8'hFF, 16'h0000);
    send_cmd(ACT_WRITE, REG_CONTROL_AMPLITUDE, 8'h7F, 16'h0000);
    send_cmd(ACT_ADVANCE, 3'd0, 8'h00, 16'hFFFF);
    send_cmd(ACT_WRITE, REG_RATE_INFLECTION, 8'h0F, 16'h0000);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i >= RANDOM_ITEMS - 100) begin
        quiet_tail = 1'b1;
      end
      random_command();
    end
    cmd_valid <= 1'b0;

    while (chip_model.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (chip_model.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
